// ----- hdl/tag_timestamp_mapper_defines.svh -----
// ----------------------------------------------------------------------------
// Tag timestamp mapper assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef TAG_TIMESTAMP_MAPPER_DEFINES_SVH
`define TAG_TIMESTAMP_MAPPER_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define TSM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tsm assertion failed");

// next-cycle implication, off while reset is asserted
`define TSM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tsm assertion failed");

// next-cycle implication, checked through reset too
`define TSM_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("tsm assertion failed");

`endif

// ----- hdl/tsm_pkg.sv -----
// ----------------------------------------------------------------------------
// Tag timestamp mapper package
// Item types, mode codes, controller states and control structs.
// ----------------------------------------------------------------------------
package tsm_pkg;

    localparam int TS_W = 64;
    localparam int ID_W = 32;

    localparam logic [ID_W-1:0] LATE_MARKER_RESET = 32'd257;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_CHUNK = 2'd1;
    localparam logic [1:0] MODE_TAG   = 2'd2;

    typedef struct packed {
        logic [1:0]      mode;
        logic [TS_W-1:0] clock_time;
        logic [TS_W-1:0] sample_time;
        logic [TS_W-1:0] tag_time;
        logic [ID_W-1:0] tag_id;
    } in_item_t;

    typedef struct packed {
        logic [ID_W-1:0] event_id;
        logic [TS_W-1:0] event_time;
        logic [TS_W-1:0] event_duration;
        logic            last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_DIVI,
        ST_DIV,
        ST_SUM,
        ST_CMP,
        ST_MARK,
        ST_TAG
    } tsm_state_t;

    typedef struct packed {
        logic       start;
        logic       chunk;
        logic       tag_load;
        logic       prep;
        logic       pp_en;
        logic [1:0] pp_sel;
        logic       acc_en;
        logic       div_init;
        logic       div_step;
        logic       sum;
        logic       cmp;
        logic       emit_mark;
        logic       emit_tag;
    } tsm_cmd_t;

    typedef struct packed {
        logic delay_nz;
        logic out_free;
    } tsm_stat_t;

endpackage

// ----- hdl/tsm_ctrl.sv -----
// ----------------------------------------------------------------------------
// Tag timestamp mapper controller
// Accepts each item and sequences multiply, divide, adjust and emit steps for each tag item.
// ----------------------------------------------------------------------------
module tsm_ctrl #(
    parameter int TIME_WIDTH = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic [1:0]         in_mode,
    output logic               s_ready,
    output tsm_pkg::tsm_cmd_t  cmd,
    input  tsm_pkg::tsm_stat_t stat
);
    import tsm_pkg::*;

    localparam int CNT_W = $clog2(TIME_WIDTH);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(4);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(TIME_WIDTH - 1);

    tsm_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                cnt_next = '0;
                if (s_valid && in_mode == MODE_TAG) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                if (cnt_reg == MUL_LAST) begin
                    state_next = ST_DIVI;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DIVI: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_SUM;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SUM: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                state_next = ST_MARK;
            end
            ST_MARK: begin
                if (!stat.delay_nz || stat.out_free) begin
                    state_next = ST_TAG;
                end
            end
            ST_TAG: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    case (in_mode)
                        MODE_START: cmd.start    = 1'b1;
                        MODE_CHUNK: cmd.chunk    = 1'b1;
                        MODE_TAG:   cmd.tag_load = 1'b1;
                        default:    ;
                    endcase
                end
            end
            ST_PREP: cmd.prep = 1'b1;
            ST_MUL: begin
                // partial products in steps 0..3, accumulate one step behind
                cmd.pp_en  = (cnt_reg < MUL_LAST);
                cmd.pp_sel = cnt_reg[1:0];
                cmd.acc_en = (cnt_reg != '0);
            end
            ST_DIVI: cmd.div_init = 1'b1;
            ST_DIV:  cmd.div_step = 1'b1;
            ST_SUM:  cmd.sum      = 1'b1;
            ST_CMP:  cmd.cmp      = 1'b1;
            ST_MARK: cmd.emit_mark = stat.delay_nz && stat.out_free;
            ST_TAG:  cmd.emit_tag  = stat.out_free;
            default: ;
        endcase
    end

endmodule

// ----- hdl/tsm_datapath.sv -----
// ----------------------------------------------------------------------------
// Tag timestamp mapper datapath
// Time state, clamp logic, split multiplier, radix-2 divider, output register.
// ----------------------------------------------------------------------------
module tsm_datapath #(
    parameter int TIME_WIDTH = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  tsm_pkg::in_item_t         s_data,
    input  logic                      cfg_wr_en,
    input  logic [tsm_pkg::ID_W-1:0]  cfg_wr_data,
    input  tsm_pkg::tsm_cmd_t         cmd,
    output tsm_pkg::tsm_stat_t        stat,
    output logic                      m_valid,
    input  logic                      m_ready,
    output tsm_pkg::out_item_t        m_data
);
    import tsm_pkg::*;

    localparam int W  = TIME_WIDTH;
    localparam int H  = (W + 1) / 2;
    localparam int PW = 2 * H;
    localparam int AW = 4 * H;

    // session state
    logic [W-1:0]    prev_clock_reg, prev_clock_next;
    logic [W-1:0]    prev_sample_reg, prev_sample_next;
    logic [W-1:0]    cur_clock_reg, cur_clock_next;
    logic [W-1:0]    cur_sample_reg, cur_sample_next;
    logic [W-1:0]    last_raw_reg, last_raw_next;
    logic [W-1:0]    last_adj_reg, last_adj_next;
    logic [ID_W-1:0] marker_id_reg, marker_id_next;
    logic            m_valid_reg, m_valid_next;

    // per-item working registers
    logic [ID_W-1:0] tag_id_reg, tag_id_next;
    logic [W-1:0]    s_reg, s_next;
    logic [W-1:0]    delay_reg, delay_next;
    logic [PW-1:0]   a_reg, a_next;
    logic [PW-1:0]   b_reg, b_next;
    logic [W-1:0]    ec_reg, ec_next;
    logic [PW-1:0]   pp_reg, pp_next;
    logic [1:0]      pp_sel_reg, pp_sel_next;
    logic [AW-1:0]   acc_reg, acc_next;
    logic [W-1:0]    rem_reg, rem_next;
    logic [W-1:0]    lo_reg, lo_next;
    logic [W-1:0]    q_reg, q_next;
    logic            sat_reg, sat_next;
    logic            ecz_reg, ecz_next;
    logic [W-1:0]    adj_reg, adj_next;
    out_item_t       m_data_reg, m_data_next;

    logic [W-1:0]  tag_in;
    logic [H-1:0]  a_part, b_part;
    logic [AW-1:0] pp_shifted;
    logic [W-1:0]  prod_hi;
    logic [W-1:0]  div_sh;
    logic          div_take;
    logic [W-1:0]  scaled;

    assign tag_in  = s_data.tag_time[W-1:0];
    assign a_part  = cmd.pp_sel[1] ? a_reg[PW-1:H] : a_reg[H-1:0];
    assign b_part  = cmd.pp_sel[0] ? b_reg[PW-1:H] : b_reg[H-1:0];
    assign prod_hi = acc_reg[2*W-1:W];
    assign div_sh  = {rem_reg[W-2:0], lo_reg[W-1]};
    // shifted-out top bit means the partial remainder already exceeds the divisor
    assign div_take = rem_reg[W-1] || (div_sh >= ec_reg);
    assign scaled  = ecz_reg ? '0 : (sat_reg ? '1 : q_reg);

    always_comb begin
        case (pp_sel_reg)
            2'd0:    pp_shifted = AW'(pp_reg);
            2'd1:    pp_shifted = AW'(pp_reg) << H;
            2'd2:    pp_shifted = AW'(pp_reg) << H;
            2'd3:    pp_shifted = AW'(pp_reg) << (2 * H);
            default: pp_shifted = AW'(pp_reg);
        endcase
    end

    always_comb begin
        prev_clock_next  = prev_clock_reg;
        prev_sample_next = prev_sample_reg;
        cur_clock_next   = cur_clock_reg;
        cur_sample_next  = cur_sample_reg;
        last_raw_next    = last_raw_reg;
        last_adj_next    = last_adj_reg;
        marker_id_next   = marker_id_reg;
        m_valid_next     = m_valid_reg;

        tag_id_next = tag_id_reg;
        s_next      = s_reg;
        delay_next  = delay_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        ec_next     = ec_reg;
        pp_next     = pp_reg;
        pp_sel_next = pp_sel_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        lo_next     = lo_reg;
        q_next      = q_reg;
        sat_next    = sat_reg;
        ecz_next    = ecz_reg;
        adj_next    = adj_reg;
        m_data_next = m_data_reg;

        if (cfg_wr_en) begin
            marker_id_next = cfg_wr_data;
        end

        if (cmd.start) begin
            prev_clock_next  = s_data.clock_time[W-1:0];
            cur_clock_next   = s_data.clock_time[W-1:0];
            prev_sample_next = '0;
            cur_sample_next  = '0;
            last_raw_next    = '0;
            last_adj_next    = '0;
        end

        if (cmd.chunk) begin
            prev_clock_next  = cur_clock_reg;
            prev_sample_next = cur_sample_reg;
            cur_clock_next   = s_data.clock_time[W-1:0];
            cur_sample_next  = s_data.sample_time[W-1:0];
        end

        if (cmd.tag_load) begin
            tag_id_next   = s_data.tag_id;
            last_raw_next = tag_in;
            // clamp to the previous raw tag first, else to the chunk start
            if (tag_in < last_raw_reg) begin
                s_next     = last_raw_reg;
                delay_next = last_raw_reg - tag_in;
            end else if (tag_in < prev_clock_reg) begin
                s_next     = prev_clock_reg;
                delay_next = prev_clock_reg - tag_in;
            end else begin
                s_next     = tag_in;
                delay_next = '0;
            end
        end

        if (cmd.prep) begin
            a_next   = (s_reg >= prev_clock_reg) ? PW'(s_reg - prev_clock_reg) : '0;
            b_next   = PW'(cur_sample_reg - prev_sample_reg);
            ec_next  = cur_clock_reg - prev_clock_reg;
            acc_next = '0;
        end

        if (cmd.pp_en) begin
            pp_next     = a_part * b_part;
            pp_sel_next = cmd.pp_sel;
        end

        if (cmd.acc_en) begin
            acc_next = acc_reg + pp_shifted;
        end

        if (cmd.div_init) begin
            rem_next = prod_hi;
            lo_next  = acc_reg[W-1:0];
            q_next   = '0;
            sat_next = (prod_hi >= ec_reg);
            ecz_next = (ec_reg == '0);
        end

        if (cmd.div_step) begin
            rem_next = div_take ? (div_sh - ec_reg) : div_sh;
            q_next   = {q_reg[W-2:0], div_take};
            lo_next  = {lo_reg[W-2:0], 1'b0};
        end

        if (cmd.sum) begin
            adj_next = prev_sample_reg + scaled;
        end

        if (cmd.cmp) begin
            if (adj_reg < last_adj_reg) begin
                delay_next = last_adj_reg - adj_reg;
                adj_next   = last_adj_reg;
            end else begin
                last_adj_next = adj_reg;
            end
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.emit_mark) begin
            m_valid_next               = 1'b1;
            m_data_next.event_id       = marker_id_reg;
            m_data_next.event_time     = TS_W'(adj_reg);
            m_data_next.event_duration = TS_W'(delay_reg);
            m_data_next.last           = 1'b0;
        end
        if (cmd.emit_tag) begin
            m_valid_next               = 1'b1;
            m_data_next.event_id       = tag_id_reg;
            m_data_next.event_time     = TS_W'(adj_reg);
            m_data_next.event_duration = '0;
            m_data_next.last           = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_clock_reg  <= '0;
            prev_sample_reg <= '0;
            cur_clock_reg   <= '0;
            cur_sample_reg  <= '0;
            last_raw_reg    <= '0;
            last_adj_reg    <= '0;
            marker_id_reg   <= LATE_MARKER_RESET;
            m_valid_reg     <= 1'b0;
        end else begin
            prev_clock_reg  <= prev_clock_next;
            prev_sample_reg <= prev_sample_next;
            cur_clock_reg   <= cur_clock_next;
            cur_sample_reg  <= cur_sample_next;
            last_raw_reg    <= last_raw_next;
            last_adj_reg    <= last_adj_next;
            marker_id_reg   <= marker_id_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        tag_id_reg <= tag_id_next;
        s_reg      <= s_next;
        delay_reg  <= delay_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        ec_reg     <= ec_next;
        pp_reg     <= pp_next;
        pp_sel_reg <= pp_sel_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        lo_reg     <= lo_next;
        q_reg      <= q_next;
        sat_reg    <= sat_next;
        ecz_reg    <= ecz_next;
        adj_reg    <= adj_next;
        m_data_reg <= m_data_next;
    end

    assign stat.delay_nz = (delay_reg != '0);
    assign stat.out_free = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_data        = m_data_reg;

endmodule

// ----- hdl/tag_timestamp_mapper.sv -----
// ----------------------------------------------------------------------------
// Tag timestamp mapper
// Maps wall-clock tag stamps onto the sample timeline of the current chunk.
// ----------------------------------------------------------------------------
// Input channel s_*: one item per handshake; mode selects start session,
// chunk boundary or tag. Mode 3 is accepted and dropped. Result channel m_*:
// zero, one or two items per input item (late marker, then the tag; the tag
// carries last = 1). cfg_wr_en / cfg_wr_data write the late marker id.
// Start and chunk items are handled on accept; s_ready stays high.
// A tag item runs from accept until its tag result is registered and s_ready
// returns: prep, the split 4-step multiply, the radix-2 divider (init, then
// its steps), sum and compare to adjust, and the marker and tag steps to
// emit.
// A finished result sits in the output register; the next item is taken
// while it waits. If the receiver stalls, the tag sequence holds in its emit
// step until the output register frees up.
// Reset clears all session time state, sets the late marker id to 257 and
// drops any pending result.
// ----------------------------------------------------------------------------
module tag_timestamp_mapper #(
    parameter int TIME_WIDTH = 64
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  tsm_pkg::in_item_t        s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output tsm_pkg::out_item_t       m_data,
    input  logic                     cfg_wr_en,
    input  logic [tsm_pkg::ID_W-1:0] cfg_wr_data
);
    import tsm_pkg::*;

    tsm_cmd_t  cmd;
    tsm_stat_t stat;

    tsm_ctrl #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .in_mode (s_data.mode),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    tsm_datapath #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

// ----- hdl/tsm_checker.sv -----
// ----------------------------------------------------------------------------
// Tag timestamp mapper checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "tag_timestamp_mapper_defines.svh"

module tsm_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input tsm_pkg::out_item_t m_data
);
    import tsm_pkg::*;

    // a stalled item holds
    `TSM_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // reset drops any pending item
    `TSM_ASSERT_NXT_ALWAYS(a_rst_clear, aclk, !aresetn, !m_valid)

    // a late marker only appears for a real delay
    `TSM_ASSERT_IMP(a_mark_dur, aclk, aresetn, m_valid && !m_data.last, m_data.event_duration != '0)

    // the tag item itself never carries a duration
    `TSM_ASSERT_IMP(a_tag_dur, aclk, aresetn, m_valid && m_data.last, m_data.event_duration == '0)

endmodule

bind tag_timestamp_mapper tsm_checker u_tsm_checker (.*);
